// ===== sv/rgrt_pkg.sv =====
// shared types, constants and codes for the rectilinear grid ray traversal block
package rgrt_pkg;

    // default node capacity per axis
    localparam int C_MAX_POINTS = 16;

    // register reset value and field widths
    localparam logic [4:0] C_PTS_RESET = 5'd16;
    localparam int C_CELL_W  = 12;
    localparam int C_PARAM_W = 48;
    localparam int C_DIV_BITS = 33;

    // saturation limits, Q32.16
    localparam logic [47:0] C_PMAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] C_POSLIM = 48'h0100_0000_0000;

    // item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RAY  = 1'b1;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_POINTS_X = 2'd0;
    localparam logic [1:0] REG_POINTS_Y = 2'd1;
    localparam logic [1:0] REG_POINTS_Z = 2'd2;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AX,
        ST_DIVW,
        ST_RD0,
        ST_RD1,
        ST_FWD,
        ST_AXW,
        ST_PICK,
        ST_SRCH_MUL,
        ST_SRCH_WAIT,
        ST_SRCH_X0,
        ST_SRCH_XH,
        ST_SRCH_LOOP,
        ST_SRCH_END,
        ST_SRCH_PM,
        ST_SRCH_PW,
        ST_RESEL,
        ST_MISS,
        ST_EMIT,
        ST_STEP_RD,
        ST_STEP_MUL,
        ST_STEP_W,
        ST_SWAP
    } t_state;

    // multiplier phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LO,
        PH_HI,
        PH_SAT
    } t_mul_ph;

    // multiplier request and response
    typedef struct packed {
        logic               start;
        logic signed [32:0] a;
        logic signed [47:0] b;
        logic               pos_lim;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic               busy;
        logic signed [47:0] res;
    } t_mul_rsp;

    // reciprocal divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] m;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [32:0] quo;
    } t_div_rsp;

endpackage

// ===== sv/rgrt_cmem.sv =====
// node coordinate memory, one write port and one registered read port
module rgrt_cmem #(
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rgrt_div.sv =====
// restoring divider for 2^32 / m, one quotient bit per cycle
module rgrt_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgrt_pkg::t_div_req  i_req,
    output rgrt_pkg::t_div_rsp  o_rsp
);
    import rgrt_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_quo, n_quo;
    logic [31:0] r_m, n_m;
    logic [32:0] shifted;
    logic        bit_in;

    // one quotient bit a cycle, dividend is a single one at bit 32
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_m    = r_m;
        bit_in  = (r_cnt == 6'(C_DIV_BITS - 1));
        shifted = {r_rem[31:0], bit_in};
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = 6'(C_DIV_BITS - 1);
            n_rem  = '0;
            n_quo  = '0;
            n_m    = i_req.m;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_m}) begin
                n_rem = shifted - {1'b0, r_m};
                n_quo = {r_quo[31:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[31:0], 1'b0};
            end
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 6'd1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_m   <= n_m;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== sv/rgrt_mul.sv =====
// saturating Q16 product, 32x32 multiplier used over two partial products
module rgrt_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgrt_pkg::t_mul_req  i_req,
    output rgrt_pkg::t_mul_rsp  o_rsp
);
    import rgrt_pkg::*;

    t_mul_ph            r_ph, n_ph;
    logic               r_done, n_done;
    logic [31:0]        r_ma, n_ma;
    logic [46:0]        r_mb, n_mb;
    logic               r_neg, n_neg;
    logic               r_pos, n_pos;
    logic [63:0]        r_acc, n_acc;
    logic signed [47:0] r_res, n_res;
    logic [32:0]        a_mag;
    logic [47:0]        b_mag;
    logic [31:0]        op_b;
    logic [63:0]        prod;
    logic [63:0]        lim;
    logic [63:0]        sat;

    // shared multiplier and phase sequence
    always_comb begin
        n_ph   = r_ph;
        n_done = 1'b0;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_neg  = r_neg;
        n_pos  = r_pos;
        n_acc  = r_acc;
        n_res  = r_res;
        a_mag  = i_req.a[32] ? 33'(-i_req.a) : i_req.a;
        b_mag  = i_req.b[47] ? 48'(-i_req.b) : i_req.b;
        op_b   = (r_ph == PH_LO) ? r_mb[31:0] : {17'd0, r_mb[46:32]};
        prod   = r_ma * op_b;
        lim    = r_pos ? {16'd0, C_POSLIM} : {16'd0, C_PMAX};
        sat    = (r_acc > lim) ? lim : r_acc;
        case (r_ph)
            PH_IDLE: begin
                if (i_req.start) begin
                    n_ma  = a_mag[31:0];
                    n_mb  = b_mag[46:0];
                    n_neg = i_req.a[32] ^ i_req.b[47];
                    n_pos = i_req.pos_lim;
                    n_ph  = PH_LO;
                end
            end
            PH_LO: begin
                n_acc = {16'd0, prod[63:16]};
                n_ph  = PH_HI;
            end
            PH_HI: begin
                n_acc = r_acc + {prod[47:0], 16'd0};
                n_ph  = PH_SAT;
            end
            PH_SAT: begin
                n_res  = r_neg ? 48'(-sat[47:0]) : sat[47:0];
                n_done = 1'b1;
                n_ph   = PH_IDLE;
            end
            default: begin
                n_ph = PH_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_neg <= n_neg;
        r_pos <= n_pos;
        r_acc <= n_acc;
        r_res <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_ph != PH_IDLE);
    assign o_rsp.res  = r_res;

endmodule

// ===== sv/rectilinear_grid_ray_traversal.sv =====
// ray traversal through a rectilinear grid: sequencer, mesh tables and output register
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------------------
//  config  | i_cfg_we                 | i_cfg_idx, i_cfg_data
//  in      | i_in_valid / o_in_stall  | i_mode, i_axis, i_node_index, i_coord_value,
//          |                          | i_ray_px/py/pz, i_ray_qx/qy/qz
//  out     | o_out_valid / i_out_stall| o_cell_index, o_path_param, o_entry_flag,
//          |                          | o_miss_flag, o_last_flag
//
// a load item goes straight to memory; a ray computes the reciprocals
// (one 33 step divider), the end node reads and the first plane parameters, then
// searches the two other axes and steps across plane crossings, sharing the
// divider, the two pass multiplier and the single read port of the memory.
// reset is synchronous and active low; it clears control state and sets the point counts to 16.
// a stalled result holds in the output register; the sequencer waits there only when
// the next result is ready.
module rectilinear_grid_ray_traversal #(
    parameter int MAX_POINTS = rgrt_pkg::C_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [1:0]         i_axis,
    input  logic [3:0]         i_node_index,
    input  logic signed [31:0] i_coord_value,
    input  logic signed [31:0] i_ray_px,
    input  logic signed [31:0] i_ray_py,
    input  logic signed [31:0] i_ray_pz,
    input  logic signed [31:0] i_ray_qx,
    input  logic signed [31:0] i_ray_qy,
    input  logic signed [31:0] i_ray_qz,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [11:0]        o_cell_index,
    output logic signed [47:0] o_path_param,
    output logic               o_entry_flag,
    output logic               o_miss_flag,
    output logic               o_last_flag
);
    import rgrt_pkg::*;

    localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int DEPTH = 3 * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);

    // memory address of one node of one axis
    function automatic logic [AW-1:0] f_addr(input logic [1:0] ax, input logic [IW-1:0] nd);
        int t;
        t = int'(ax) * MAX_POINTS + int'(nd);
        return t[AW-1:0];
    endfunction

    // node count clamped to 1..MAX_POINTS
    function automatic logic [NW-1:0] f_sat(input logic [4:0] v);
        logic [NW-1:0] r;
        if (v == 5'd0) begin
            r = NW'(1);
        end else if (int'(v) > MAX_POINTS) begin
            r = NW'(MAX_POINTS);
        end else begin
            r = NW'(v);
        end
        return r;
    endfunction

    // stride of an axis
    function automatic logic [11:0] f_stride(input logic [1:0] ax, input logic [11:0] s1,
                                             input logic [11:0] s2);
        logic [11:0] r;
        case (ax)
            AXIS_X:  r = 12'd1;
            AXIS_Y:  r = s1;
            default: r = s2;
        endcase
        return r;
    endfunction

    // cell contribution of one axis, cell numbered by its higher node
    function automatic logic [11:0] f_term(input logic [IW-1:0] idx, input logic bwd,
                                           input logic [11:0] stride);
        logic [NW:0]  s;
        logic [NW+12:0] pr;
        s  = (NW+1)'(idx) + (NW+1)'(bwd);
        pr = (NW+13)'(s) * (NW+13)'(stride);
        return pr[11:0];
    endfunction

    // coordinate difference, 33 bit signed
    function automatic logic signed [32:0] f_diff(input logic signed [31:0] x,
                                                  input logic signed [31:0] p);
        return {x[31], x} - {p[31], p};
    endfunction

    // state
    t_state                r_state, n_state;
    logic [1:0]            r_a, n_a;
    logic                  r_k, n_k;
    logic [1:0]            r_i, n_i;
    logic [1:0]            r_j, n_j;
    logic signed [31:0]    r_p [3];
    logic signed [31:0]    n_p [3];
    logic signed [31:0]    r_q [3];
    logic signed [31:0]    n_q [3];
    logic signed [47:0]    r_inv [3];
    logic signed [47:0]    n_inv [3];
    logic                  r_fwd [3];
    logic                  n_fwd [3];
    logic [IW-1:0]         r_nn [3];
    logic [IW-1:0]         n_nn [3];
    logic signed [47:0]    r_np [3];
    logic signed [47:0]    n_np [3];
    logic [NW-1:0]         r_n [3];
    logic [NW-1:0]         n_n [3];
    logic [4:0]            r_pts [3];
    logic [11:0]           r_s1, n_s1;
    logic [11:0]           r_s2, n_s2;
    logic [11:0]           r_cell, n_cell;
    logic signed [31:0]    r_x0, n_x0;
    logic signed [47:0]    r_pos, n_pos;
    logic                  r_asc, n_asc;
    logic [IW-1:0]         r_lo, n_lo;
    logic [IW-1:0]         r_hi, n_hi;
    logic [IW-1:0]         r_mid, n_mid;
    logic                  r_first, n_first;
    logic                  r_ovalid, n_ovalid;
    logic [11:0]           r_ocell, n_ocell;
    logic signed [47:0]    r_oparam, n_oparam;
    logic                  r_oentry, n_oentry;
    logic                  r_omiss, n_omiss;
    logic                  r_olast, n_olast;

    // shared units and memory
    t_mul_req              mul_req;
    t_mul_rsp              mul_rsp;
    t_div_req              div_req;
    t_div_rsp              div_rsp;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         rd_addr;
    logic [31:0]           rd_data;

    // combinational temporaries
    logic                  in_acc;
    logic                  out_free;
    logic [NW-1:0]         sat0, sat1, sat2;
    logic [23:0]           s2_full;
    logic [1:0]            pick_i;
    logic [1:0]            oth;
    logic [1:0]            jn;
    logic signed [31:0]    qa, xd, xs;
    logic [31:0]           qmag;
    logic [47:0]           vz;
    logic [NW-1:0]         nm1_a, nm1_j, nm1_i;
    logic                  fwd_a;
    logic signed [47:0]    xs0, xsh, xsm;
    logic                  asc, fail, go_lo;
    logic [IW-1:0]         mid0, nlo, nhi, nmid, idx;
    logic [IW:0]           msum;
    logic [11:0]           stride_i, stride_j;
    logic                  brk;
    logic [1:0]            so;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_ovalid || !i_out_stall;

    assign mem_we    = in_acc && (i_mode == MODE_LOAD) && (i_axis != AXIS_NONE)
                       && (int'(i_node_index) < MAX_POINTS);
    assign mem_waddr = f_addr(i_axis, IW'(i_node_index));

    rgrt_cmem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_coord_value),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    rgrt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    rgrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer: next state, datapath updates and unit requests
    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_p      = r_p;
        n_q      = r_q;
        n_inv    = r_inv;
        n_fwd    = r_fwd;
        n_nn     = r_nn;
        n_np     = r_np;
        n_n      = r_n;
        n_s1     = r_s1;
        n_s2     = r_s2;
        n_cell   = r_cell;
        n_x0     = r_x0;
        n_pos    = r_pos;
        n_asc    = r_asc;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_first  = r_first;
        n_ovalid = r_ovalid && i_out_stall;
        n_ocell  = r_ocell;
        n_oparam = r_oparam;
        n_oentry = r_oentry;
        n_omiss  = r_omiss;
        n_olast  = r_olast;
        mul_req  = '0;
        div_req  = '0;
        rd_addr  = '0;

        sat0    = f_sat(r_pts[0]);
        sat1    = f_sat(r_pts[1]);
        sat2    = f_sat(r_pts[2]);
        s2_full = 24'(sat0) * 24'(sat1);

        // entry face: largest plane parameter
        if (r_np[2] > r_np[1]) begin
            pick_i = (r_np[2] > r_np[0]) ? AXIS_Z : AXIS_X;
        end else begin
            pick_i = (r_np[1] > r_np[0]) ? AXIS_Y : AXIS_X;
        end
        oth = 2'd3 - r_i - r_j;
        jn  = (r_j == AXIS_X) ? AXIS_Z : (r_j - 2'd1);

        qa    = r_q[r_a];
        qmag  = qa[31] ? 32'(-qa) : qa;
        vz    = {15'd0, div_rsp.quo};
        nm1_a = r_n[r_a] - NW'(1);
        nm1_j = r_n[r_j] - NW'(1);
        nm1_i = r_n[r_i] - NW'(1);
        fwd_a = r_inv[r_a][47] ? (r_x0 >= $signed(rd_data)) : (r_x0 < $signed(rd_data));
        xd    = $signed(rd_data);
        xs    = fwd_a ? r_x0 : xd;

        xs0   = {{16{r_x0[31]}}, r_x0};
        xsh   = {{16{rd_data[31]}}, rd_data};
        xsm   = xsh;
        asc   = (r_x0 < xd);
        fail  = (r_n[r_j] == NW'(1)) || (r_x0 == xd)
                || (asc ? ((r_pos < xs0) || (r_pos > xsh))
                        : ((r_pos > xs0) || (r_pos < xsh)));
        mid0  = nm1_j[IW-1:0] >> 1;
        go_lo = r_asc ? (xsm < r_pos) : (xsm > r_pos);
        nlo   = go_lo ? r_mid : r_lo;
        nhi   = go_lo ? r_hi : r_mid;
        msum  = {1'b0, nlo} + {1'b0, nhi};
        nmid  = msum[IW:1];
        idx   = r_fwd[r_j] ? r_hi : r_lo;

        stride_i = f_stride(r_i, r_s1, r_s2);
        stride_j = f_stride(r_j, r_s1, r_s2);
        brk      = r_fwd[r_i] ? (r_nn[r_i] == nm1_i[IW-1:0]) : (r_nn[r_i] == '0);
        so       = (r_np[r_i] < r_np[oth]) ? r_i : oth;

        case (r_state)
            // take a ray; load items go straight to memory
            ST_IDLE: begin
                if (in_acc && (i_mode == MODE_RAY)) begin
                    n_p[0] = i_ray_px;
                    n_p[1] = i_ray_py;
                    n_p[2] = i_ray_pz;
                    n_q[0] = i_ray_qx;
                    n_q[1] = i_ray_qy;
                    n_q[2] = i_ray_qz;
                    n_n[0] = sat0;
                    n_n[1] = sat1;
                    n_n[2] = sat2;
                    n_s1   = 12'(sat0);
                    n_s2   = s2_full[11:0];
                    n_a    = AXIS_X;
                    n_state = ST_AX;
                end
            end
            // reciprocal of one direction component
            ST_AX: begin
                if (qa == '0) begin
                    n_inv[r_a] = C_PMAX;
                    n_state    = ST_RD0;
                end else begin
                    div_req.start = 1'b1;
                    div_req.m     = qmag;
                    n_state       = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (div_rsp.done) begin
                    n_inv[r_a] = qa[31] ? 48'(-vz) : vz;
                    n_state    = ST_RD0;
                end
            end
            // end nodes of the axis
            ST_RD0: begin
                rd_addr = f_addr(r_a, '0);
                n_state = ST_RD1;
            end
            ST_RD1: begin
                n_x0    = xd;
                rd_addr = f_addr(r_a, nm1_a[IW-1:0]);
                n_state = ST_FWD;
            end
            // stepping direction and first plane parameter
            ST_FWD: begin
                n_fwd[r_a]      = fwd_a;
                n_nn[r_a]       = fwd_a ? '0 : nm1_a[IW-1:0];
                mul_req.start   = 1'b1;
                mul_req.a       = f_diff(xs, r_p[r_a]);
                mul_req.b       = r_inv[r_a];
                mul_req.pos_lim = 1'b0;
                n_state         = ST_AXW;
            end
            ST_AXW: begin
                if (mul_rsp.done) begin
                    n_np[r_a] = mul_rsp.res;
                    if (r_a == AXIS_Z) begin
                        n_state = ST_PICK;
                    end else begin
                        n_a     = r_a + 2'd1;
                        n_state = ST_AX;
                    end
                end
            end
            // entry face and its cell term
            ST_PICK: begin
                n_i     = pick_i;
                n_j     = pick_i;
                n_k     = 1'b0;
                n_first = 1'b1;
                n_cell  = f_term(r_nn[pick_i], !r_fwd[pick_i],
                                 f_stride(pick_i, r_s1, r_s2));
                n_state = ST_SRCH_MUL;
            end
            // position on the next axis at the entry parameter
            ST_SRCH_MUL: begin
                n_j             = jn;
                mul_req.start   = 1'b1;
                mul_req.a       = {r_q[jn][31], r_q[jn]};
                mul_req.b       = r_np[r_i];
                mul_req.pos_lim = 1'b1;
                n_state         = ST_SRCH_WAIT;
            end
            ST_SRCH_WAIT: begin
                rd_addr = f_addr(r_j, '0);
                if (mul_rsp.done) begin
                    n_pos   = {{16{r_p[r_j][31]}}, r_p[r_j]} + mul_rsp.res;
                    n_state = ST_SRCH_X0;
                end
            end
            ST_SRCH_X0: begin
                n_x0    = xd;
                rd_addr = f_addr(r_j, nm1_j[IW-1:0]);
                n_state = ST_SRCH_XH;
            end
            // range check, then binary search
            ST_SRCH_XH: begin
                n_asc = asc;
                n_lo  = '0;
                n_hi  = nm1_j[IW-1:0];
                n_mid = mid0;
                rd_addr = f_addr(r_j, mid0);
                if (fail) begin
                    n_state = ST_MISS;
                end else if (mid0 != '0) begin
                    n_state = ST_SRCH_LOOP;
                end else begin
                    n_state = ST_SRCH_END;
                end
            end
            ST_SRCH_LOOP: begin
                n_lo    = nlo;
                n_hi    = nhi;
                n_mid   = nmid;
                rd_addr = f_addr(r_j, nmid);
                if (nmid <= nlo) begin
                    n_state = ST_SRCH_END;
                end
            end
            ST_SRCH_END: begin
                n_nn[r_j] = idx;
                n_cell    = r_cell + f_term(idx, !r_fwd[r_j], stride_j);
                rd_addr   = f_addr(r_j, idx);
                n_state   = ST_SRCH_PM;
            end
            // plane parameter of the located node
            ST_SRCH_PM: begin
                mul_req.start   = 1'b1;
                mul_req.a       = f_diff(xd, r_p[r_j]);
                mul_req.b       = r_inv[r_j];
                mul_req.pos_lim = 1'b0;
                n_state         = ST_SRCH_PW;
            end
            ST_SRCH_PW: begin
                if (mul_rsp.done) begin
                    n_np[r_j] = mul_rsp.res;
                    if (r_k) begin
                        n_state = ST_RESEL;
                    end else begin
                        n_k     = 1'b1;
                        n_state = ST_SRCH_MUL;
                    end
                end
            end
            // nearer of the two other planes
            ST_RESEL: begin
                if (r_np[r_j] > r_np[oth]) begin
                    n_j = oth;
                end
                n_state = ST_EMIT;
            end
            ST_MISS: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ocell  = '0;
                    n_oparam = r_np[r_i];
                    n_oentry = 1'b1;
                    n_omiss  = 1'b1;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            // emit the current cell and step across the next plane
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ocell  = r_cell;
                    n_oparam = r_np[r_i];
                    n_oentry = r_first;
                    n_omiss  = 1'b0;
                    n_olast  = brk;
                    n_first  = 1'b0;
                    if (brk) begin
                        n_state = ST_IDLE;
                    end else begin
                        if (r_fwd[r_i]) begin
                            n_nn[r_i] = r_nn[r_i] + IW'(1);
                            n_cell    = r_cell + stride_i;
                        end else begin
                            n_nn[r_i] = r_nn[r_i] - IW'(1);
                            n_cell    = r_cell - stride_i;
                        end
                        n_state = ST_STEP_RD;
                    end
                end
            end
            ST_STEP_RD: begin
                rd_addr = f_addr(r_i, r_nn[r_i]);
                n_state = ST_STEP_MUL;
            end
            ST_STEP_MUL: begin
                mul_req.start   = 1'b1;
                mul_req.a       = f_diff(xd, r_p[r_i]);
                mul_req.b       = r_inv[r_i];
                mul_req.pos_lim = 1'b0;
                n_state         = ST_STEP_W;
            end
            ST_STEP_W: begin
                if (mul_rsp.done) begin
                    n_np[r_i] = mul_rsp.res;
                    n_state   = ST_SWAP;
                end
            end
            // rotate the axis roles when another plane comes first
            ST_SWAP: begin
                if (r_np[r_i] > r_np[r_j]) begin
                    n_i = r_j;
                    n_j = so;
                end
                n_state = ST_EMIT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_pts[0] <= C_PTS_RESET;
            r_pts[1] <= C_PTS_RESET;
            r_pts[2] <= C_PTS_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POINTS_X: r_pts[0] <= i_cfg_data;
                    REG_POINTS_Y: r_pts[1] <= i_cfg_data;
                    REG_POINTS_Z: r_pts[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_k      <= n_k;
        r_i      <= n_i;
        r_j      <= n_j;
        r_p      <= n_p;
        r_q      <= n_q;
        r_inv    <= n_inv;
        r_fwd    <= n_fwd;
        r_nn     <= n_nn;
        r_np     <= n_np;
        r_n      <= n_n;
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_cell   <= n_cell;
        r_x0     <= n_x0;
        r_pos    <= n_pos;
        r_asc    <= n_asc;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_first  <= n_first;
        r_ocell  <= n_ocell;
        r_oparam <= n_oparam;
        r_oentry <= n_oentry;
        r_omiss  <= n_omiss;
        r_olast  <= n_olast;
    end

    assign o_out_valid  = r_ovalid;
    assign o_cell_index = r_ocell;
    assign o_path_param = r_oparam;
    assign o_entry_flag = r_oentry;
    assign o_miss_flag  = r_omiss;
    assign o_last_flag  = r_olast;

    // checks
    a_roles_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_i != r_j))
        else $error("entry and next axis coincide while stepping");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_EMIT || r_state == ST_MISS))
        else $error("result item raised outside an emit state");

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (!div_rsp.busy && r_state == ST_AX))
        else $error("divider started while busy");

endmodule

// ===== verif/rectilinear_grid_ray_traversal_tb.sv =====
// testbench for the rectilinear grid ray traversal block: directed and random items against a predictor
module rectilinear_grid_ray_traversal_tb;
    import rgrt_pkg::*;

    localparam int    NPTS   = C_MAX_POINTS;
    localparam longint PSAT  = 64'sh7FFF_FFFF_FFFF;
    localparam longint PLIM  = 64'sh100_0000_0000;
    localparam int    UNIT   = 65536;

    // one input item
    typedef struct {
        logic        mode;
        logic [1:0]  axis;
        logic [3:0]  node;
        logic [31:0] coord;
        logic [31:0] p [3];
        logic [31:0] q [3];
    } t_item;

    // one result item
    typedef struct packed {
        logic [11:0] cidx;
        logic [47:0] param;
        logic        entry;
        logic        miss;
        logic        last;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [4:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_mode = 1'b0;
    logic [1:0] i_axis = '0;
    logic [3:0] i_node_index = '0;
    logic signed [31:0] i_coord_value = '0;
    logic signed [31:0] i_ray_px = '0, i_ray_py = '0, i_ray_pz = '0;
    logic signed [31:0] i_ray_qx = '0, i_ray_qy = '0, i_ray_qz = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [11:0] o_cell_index;
    logic signed [47:0] o_path_param;
    logic o_entry_flag, o_miss_flag, o_last_flag;

    // predictor state and expected hits
    int     mesh_coord [3][NPTS];
    int     pts_reg [3];
    t_hit   pending_hits [$];
    int     accepted_cnt = 0;
    int     errors = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     hold_off = 0;

    rectilinear_grid_ray_traversal DUT (.*);

    always #6 i_clk = ~i_clk;

    // fixed point product, truncated toward zero and saturated
    function automatic longint mul_q16(longint a, longint b, longint lim);
        bit neg;
        logic [127:0] ma, mb, r;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? 128'(-a) : 128'(a);
        mb = b < 0 ? 128'(-b) : 128'(b);
        r = (ma * mb) >> 16;
        if (r > 128'(lim)) r = 128'(lim);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic int used_points(int a);
        if (pts_reg[a] < 1) return 1;
        if (pts_reg[a] > NPTS) return NPTS;
        return pts_reg[a];
    endfunction

    // binary search of a position among the nodes of one axis, -1 outside
    function automatic int find_node(int a, int n, longint pos, bit fwd);
        int hi, lo, mid;
        hi = n - 1;
        lo = 0;
        if (hi < 1 || mesh_coord[a][0] == mesh_coord[a][hi]) return -1;
        if (mesh_coord[a][0] < mesh_coord[a][hi]) begin
            if (pos < mesh_coord[a][0] || pos > mesh_coord[a][hi]) return -1;
            for (mid = hi / 2; mid > lo; mid = (lo + hi) / 2) begin
                if (mesh_coord[a][mid] < pos) lo = mid; else hi = mid;
            end
        end else begin
            if (pos > mesh_coord[a][0] || pos < mesh_coord[a][hi]) return -1;
            for (mid = hi / 2; mid > lo; mid = (lo + hi) / 2) begin
                if (mesh_coord[a][mid] > pos) lo = mid; else hi = mid;
            end
        end
        return fwd ? hi : lo;
    endfunction

    function automatic t_hit make_hit(int cidx, longint s, bit entry, bit miss);
        t_hit h;
        h.cidx = cidx[11:0];
        h.param = s[47:0];
        h.entry = entry;
        h.miss = miss;
        h.last = 1'b0;
        return h;
    endfunction

    // trace one ray through the mesh and queue the cells it crosses
    task automatic trace_ray(t_item it);
        longint p [3], q [3], inv [3], np [3], pos, r;
        int n [3], nn [3], stride [3], i, j, k, o, idx, cidx, cur;
        bit fwd [3];
        bit ok;
        t_hit h;
        ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            p[a] = longint'(signed'(it.p[a]));
            q[a] = longint'(signed'(it.q[a]));
            n[a] = used_points(a);
        end
        stride[0] = 1;
        stride[1] = n[0];
        stride[2] = n[0] * n[1];
        for (int a = 0; a < 3; a++) begin
            if (q[a] == 0) r = PSAT;
            else begin
                r = 64'h1_0000_0000 / (q[a] < 0 ? -q[a] : q[a]);
                if (q[a] < 0) r = -r;
            end
            inv[a] = r;
            if (r < 0) fwd[a] = mesh_coord[a][0] >= mesh_coord[a][n[a] - 1];
            else fwd[a] = mesh_coord[a][0] < mesh_coord[a][n[a] - 1];
            nn[a] = fwd[a] ? 0 : n[a] - 1;
            np[a] = mul_q16(longint'(mesh_coord[a][nn[a]]) - p[a], r, PSAT);
        end
        // entry face is the axis with the largest plane parameter
        if (np[2] > np[1]) i = (np[2] > np[0]) ? 2 : 0;
        else i = (np[1] > np[0]) ? 1 : 0;
        cidx = (nn[i] + (fwd[i] ? 0 : 1)) * stride[i];
        j = i;
        for (k = 0; k < 2; k++) begin
            j = j ? j - 1 : 2;
            pos = p[j] + mul_q16(q[j], np[i], PLIM);
            idx = find_node(j, n[j], pos, fwd[j]);
            if (idx >= 0 && ok) begin
                nn[j] = idx;
                cidx += (idx + (fwd[j] ? 0 : 1)) * stride[j];
                np[j] = mul_q16(longint'(mesh_coord[j][idx]) - p[j], inv[j], PSAT);
            end else ok = 1'b0;
        end
        if (!ok) begin
            h = make_hit(0, np[i], 1'b1, 1'b1);
            h.last = 1'b1;
            pending_hits.push_back(h);
            return;
        end
        cur = cidx;
        h = make_hit(cidx, np[i], 1'b1, 1'b0);
        if (np[j] > np[3 - i - j]) j = 3 - i - j;
        // plane crossings until an axis runs off its end
        while (1) begin
            if (fwd[i]) begin
                nn[i]++;
                if (nn[i] >= n[i]) break;
                cur += stride[i];
            end else begin
                nn[i]--;
                if (nn[i] < 0) break;
                cur -= stride[i];
            end
            np[i] = mul_q16(longint'(mesh_coord[i][nn[i]]) - p[i], inv[i], PSAT);
            if (np[i] > np[j]) begin
                o = 3 - i - j;
                if (np[i] < np[o]) o = i;
                i = j;
                j = o;
            end
            pending_hits.push_back(h);
            h = make_hit(cur, np[i], 1'b0, 1'b0);
        end
        h.last = 1'b1;
        pending_hits.push_back(h);
    endtask

    // accepted items and register writes update the predictor
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n && i_cfg_we && i_cfg_idx <= REG_POINTS_Z)
            pts_reg[i_cfg_idx] = int'(i_cfg_data);
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            it.mode = i_mode;
            it.p = '{i_ray_px, i_ray_py, i_ray_pz};
            it.q = '{i_ray_qx, i_ray_qy, i_ray_qz};
            if (i_mode == MODE_LOAD) begin
                if (i_axis != AXIS_NONE) mesh_coord[i_axis][i_node_index] = i_coord_value;
            end else trace_ray(it);
            accepted_cnt++;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_hit got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_cell_index, o_path_param, o_entry_flag, o_miss_flag, o_last_flag};
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected item, actual %p", $time, got);
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch, expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(t_item it);
        int start;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        start = accepted_cnt;
        i_in_valid = 1'b1;
        i_mode = it.mode;
        i_axis = it.axis;
        i_node_index = it.node;
        i_coord_value = it.coord;
        {i_ray_px, i_ray_py, i_ray_pz} = {it.p[0], it.p[1], it.p[2]};
        {i_ray_qx, i_ray_qy, i_ray_qz} = {it.q[0], it.q[1], it.q[2]};
        while (accepted_cnt == start) @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic t_item load_item(logic [1:0] ax, logic [3:0] nd, logic [31:0] v);
        t_item it;
        it.mode = MODE_LOAD;
        it.axis = ax;
        it.node = nd;
        it.coord = v;
        it.p = '{$urandom, $urandom, $urandom};
        it.q = '{$urandom, $urandom, $urandom};
        return it;
    endfunction

    function automatic t_item ray_item(logic [31:0] p [3], logic [31:0] q [3]);
        t_item it;
        it.mode = MODE_RAY;
        it.axis = 2'($urandom);
        it.node = 4'($urandom);
        it.coord = $urandom;
        it.p = p;
        it.q = q;
        return it;
    endfunction

    // wait until every result is in and the block has gone quiet
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_points(int nx, int ny, int nz);
        write_reg(REG_POINTS_X, 5'(nx));
        write_reg(REG_POINTS_Y, 5'(ny));
        write_reg(REG_POINTS_Z, 5'(nz));
    endtask

    // nonuniform node coordinates, increasing or decreasing per axis
    task automatic build_mesh(bit down_x, bit down_y, bit down_z);
        bit down [3];
        int v;
        down = '{down_x, down_y, down_z};
        for (int a = 0; a < 3; a++) begin
            v = 0;
            for (int k = 0; k < NPTS; k++) begin
                send_item(load_item(2'(a), 4'(down[a] ? NPTS - 1 - k : k), v));
                v += $urandom_range(3 * UNIT, UNIT / 4);
            end
        end
    endtask

    // ray aimed from a random nearby origin at a point near a node of the mesh
    function automatic t_item aimed_ray();
        logic [31:0] p [3], q [3];
        int tgt, org, n;
        for (int a = 0; a < 3; a++) begin
            n = used_points(a);
            tgt = mesh_coord[a][$urandom_range(n - 1)] + $urandom_range(UNIT) - UNIT / 2;
            org = tgt + int'($urandom_range(80 * UNIT)) - 40 * UNIT;
            p[a] = org;
            q[a] = (tgt - org) >>> $urandom_range(6);
            if ($urandom_range(19) == 0) q[a] = 0;
        end
        return ray_item(p, q);
    endfunction

    function automatic t_item noise_ray();
        logic [31:0] p [3], q [3];
        p = '{$urandom, $urandom, $urandom};
        q = '{$urandom, $urandom, $urandom};
        return ray_item(p, q);
    endfunction

    // rays mixed with node rewrites and ignored loads
    task automatic run_random(int count);
        int pick, a, nd;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            a = $urandom_range(2);
            nd = $urandom_range(NPTS - 1);
            if (pick < 75) send_item(aimed_ray());
            else if (pick < 85) send_item(noise_ray());
            else if (pick < 92) send_item(load_item(2'(a), 4'(nd), mesh_coord[a][nd]));
            else send_item(load_item(AXIS_NONE, 4'(nd), $urandom));
        end
    endtask

    task automatic test_directed();
        logic [31:0] p [3], q [3];
        build_mesh(0, 0, 1);
        send_item(load_item(AXIS_NONE, 4'hF, 32'hFFFF_FFFF));
        // axis-aligned ray along x through the mesh
        p = '{-32'sd5 * UNIT, UNIT / 2, mesh_coord[2][0] - UNIT / 2};
        q = '{UNIT, 0, 0};
        send_item(ray_item(p, q));
        // reversed direction on every axis
        p = '{200 * UNIT, 200 * UNIT, -32'sd100 * UNIT};
        q = '{-32'sd7 * UNIT, -32'sd7 * UNIT, -32'sd5 * UNIT};
        send_item(ray_item(p, q));
        // zero direction everywhere
        p = '{UNIT, UNIT, UNIT};
        q = '{0, 0, 0};
        send_item(ray_item(p, q));
        // miss: pointing away from the mesh on x and y
        p = '{-32'sd50 * UNIT, -32'sd50 * UNIT, -32'sd50 * UNIT};
        q = '{-UNIT, -UNIT, UNIT};
        send_item(ray_item(p, q));
        // extreme origins and directions
        p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        q = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        send_item(ray_item(p, q));
        p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        q = '{32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
        send_item(ray_item(p, q));
        // tiny direction, sentinel-sized parameters
        p = '{-32'sd1, -32'sd1, -32'sd1};
        q = '{1, 1, 1};
        send_item(ray_item(p, q));
        for (int k = 0; k < 4; k++) send_item(aimed_ray());
        drain();
    endtask

    task automatic test_register_extremes();
        logic [31:0] p [3], q [3];
        // out of range counts saturate
        set_points(0, 31, 17);
        for (int k = 0; k < 3; k++) send_item(aimed_ray());
        drain();
        // single node on an axis searched: miss
        set_points(16, 1, 16);
        for (int k = 0; k < 3; k++) send_item(aimed_ray());
        drain();
        set_points(2, 2, 2);
        for (int k = 0; k < 4; k++) send_item(aimed_ray());
        drain();
        // equal end coordinates
        send_item(load_item(AXIS_Y, 1, mesh_coord[1][0]));
        p = '{-32'sd3 * UNIT, UNIT, UNIT};
        q = '{UNIT, UNIT / 8, UNIT / 8};
        send_item(ray_item(p, q));
        send_item(load_item(AXIS_Y, 0, 32'h7FFF_FFFF));
        send_item(load_item(AXIS_Y, 1, 32'h8000_0000));
        send_item(ray_item(p, q));
        drain();
        set_points(16, 16, 16);
        build_mesh(1, 0, 0);
    endtask

    // full range noise loads, then a clean mesh again
    task automatic test_noise_loads();
        for (int k = 0; k < 12; k++)
            send_item(load_item(2'($urandom_range(3)), 4'($urandom), $urandom));
        for (int k = 0; k < 6; k++) send_item(noise_ray());
        drain();
        build_mesh($urandom_range(1), $urandom_range(1), $urandom_range(1));
    endtask

    task automatic test_idle_phases();
        int idle_tab [4] = '{0, 54, 0, 29};
        int stall_tab [4] = '{0, 0, 54, 29};
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            drain();
            set_points($urandom_range(16, 2), $urandom_range(16, 2), $urandom_range(16, 2));
            run_random(48);
            drain();
            set_points(16, 16, 16);
            if (ph == 2) build_mesh($urandom_range(1), $urandom_range(1), $urandom_range(1));
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    // long receiver hold-off while the sender keeps going, then random receiver stalls
    task automatic test_backpressure();
        hold_off = 3000;
        run_random(30);
        drain();
        stall_pct = 20;
        run_random(20);
        drain();
        stall_pct = 0;
    endtask

    initial begin
        pts_reg = '{16, 16, 16};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_register_extremes();
        test_noise_loads();
        test_idle_phases();
        test_backpressure();
        drain();
        if (errors == 0 && pending_hits.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
